// ===== rtl/itf_pkg.sv =====
// Shared types and constants for the instruction trace fingerprint block.
// Holds the FNV-1a constants, register indexes and reset values.
// No dependencies.
`default_nettype none

package itf_pkg;

   // Defaults for the top-level parameters.
   localparam int CPU_COUNT_DEFAULT      = 256;
   localparam int MAX_CODE_BYTES_DEFAULT = 16;

   // Bytes hashed ahead of the code bytes: cpu index, pc and length, eight each.
   localparam int HDR_BYTES = 24;

   localparam int LEN_W  = 5;
   localparam int WORD_W = 64;
   localparam int CSR_IDX_W = 2;

   // FNV-1a 64 constants. The prime is 2^40 + 0x1b3.
   localparam logic [WORD_W-1:0] FNV_OFFSET      = 64'hcbf2_9ce4_8422_2325;
   localparam logic [8:0]        FNV_PRIME_LOW   = 9'h1b3;
   localparam int                FNV_PRIME_SHIFT = 40;

   localparam logic [WORD_W-1:0] INTERVAL_RESET = 64'd100000;
   localparam logic [WORD_W-1:0] ALL_ONES       = {WORD_W{1'b1}};

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WATCH_PC        = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_HASH = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/instruction_trace_fingerprint.sv =====
// Top level of the instruction trace fingerprint block: a byte-serial FNV-1a 64
// hash of retired instructions with retirement counters, sampling and stop flags.
// Depends on itf_pkg.
`default_nettype none

// Usage
// -----
// Each request on the req_ channel is one retired instruction. Its cpu index, pc
// and clamped length (eight little-endian bytes each) and then its valid code
// bytes are loaded into a byte shift register and folded into the running hash
// one byte per cycle. One result leaves on the rsp_ channel for every request.
// A request with clamped length L is hashed as 24 + L bytes; the block then moves
// to the done state, loads the result register once it is free and returns to
// idle with req_ready high. A new request is accepted only after the previous
// result has been loaded: the single byte-round unit (a 64 by 9 bit multiply
// plus a shifted add) works on one request at a time.
// req_ready is high only while no request is in flight.
// The per-cpu counters sit in a memory read at the accept edge and written back
// on the first hash cycle; a valid bit per entry makes them read as zero after
// reset, so no clearing pass is needed.
// Reset (synchronous, active high) restores the offset basis, clears the
// counters and flags and loads the register reset values.
// A finished result waits in the output register while rsp_ready is low; the
// next request may already be accepted and hashed, and only its hand-over to the
// output register waits until the earlier result has been taken.
// Configuration writes on the csr_ port take effect at once; the user must make
// them only while the block is idle, as the block itself does not enforce this.

module instruction_trace_fingerprint
   import itf_pkg::*;
#(
   parameter int CPU_COUNT      = CPU_COUNT_DEFAULT,
   parameter int MAX_CODE_BYTES = MAX_CODE_BYTES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [7:0]           req_cpu_index,
   input  wire logic [WORD_W-1:0]    req_insn_pc,
   input  wire logic [LEN_W-1:0]     req_insn_len,
   input  wire logic [WORD_W-1:0]    req_code_bytes_low,
   input  wire logic [WORD_W-1:0]    req_code_bytes_high,

   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [WORD_W-1:0]    rsp_stream_fingerprint,
   output      logic [WORD_W-1:0]    rsp_retired_total,
   output      logic [WORD_W-1:0]    rsp_cpu_retired,
   output      logic                 rsp_sample_due,
   output      logic                 rsp_stop_hit,
   output      logic                 rsp_watch_seen,
   output      logic [WORD_W-1:0]    rsp_watch_first_count,

   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata
);

   localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
   localparam int SR_W   = (HDR_BYTES + MAX_CODE_BYTES) * 8;
   localparam int CODE_W = MAX_CODE_BYTES * 8;
   localparam int STEP_W = $clog2(HDR_BYTES + MAX_CODE_BYTES + 1);

   // Configuration registers.
   logic [WORD_W-1:0] interval_ff;
   logic [WORD_W-1:0] stop_count_ff;
   logic [WORD_W-1:0] watch_pc_ff;

   // Block state.
   state_type         state_ff, state_in;
   logic [WORD_W-1:0] hash_ff, hash_in;
   logic [WORD_W-1:0] total_ff;
   logic [WORD_W-1:0] next_point_ff;
   logic              stop_done_ff;
   logic              watch_hit_ff;
   logic [WORD_W-1:0] watch_count_ff;

   // Per-request working registers.
   logic [SR_W-1:0]   sr_ff, sr_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] nbytes_ff;
   logic [WORD_W-1:0] pc_ff;
   logic [CPU_W-1:0]  cpu_ff;
   logic              in_range_ff;
   logic [WORD_W-1:0] cnt_ff;
   logic              sample_ff;
   logic              stop_ff;

   // Per-cpu counter memory.
   logic [WORD_W-1:0] cpu_mem [CPU_COUNT];
   logic [CPU_COUNT-1:0] cpu_vld_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_vld_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_hash_ff;
   logic [WORD_W-1:0] rsp_total_ff;
   logic [WORD_W-1:0] rsp_cnt_ff;
   logic              rsp_sample_ff;
   logic              rsp_stop_ff;
   logic              rsp_seen_ff;
   logic [WORD_W-1:0] rsp_watch_count_ff;

   logic              accept;
   logic              first_step;
   logic              second_step;
   logic              last_step;
   logic              rsp_load;
   logic              req_in_range;
   logic [LEN_W-1:0]  len_clamped;
   logic [127:0]      code_all;
   logic [WORD_W-1:0] mix_x;
   logic [WORD_W-1:0] cnt_in;
   logic [WORD_W:0]   next_sum;

   assign accept       = req_valid && req_ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign first_step   = (state_ff == ST_HASH) && (step_ff == '0);
   assign second_step  = (state_ff == ST_HASH) && (step_ff == STEP_W'(1));
   assign last_step    = (state_ff == ST_HASH) && (step_ff == nbytes_ff - STEP_W'(1));
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign req_in_range = ({1'b0, req_cpu_index} < 9'(CPU_COUNT));

   // Lengths beyond the code byte capacity are clamped before hashing.
   assign len_clamped = (req_insn_len > LEN_W'(MAX_CODE_BYTES)) ?
                        LEN_W'(MAX_CODE_BYTES) : req_insn_len;
   assign code_all    = {req_code_bytes_high, req_code_bytes_low};

   // One FNV-1a round: xor in the byte, then multiply by 2^40 + 0x1b3.
   assign mix_x   = hash_ff ^ {{(WORD_W-8){1'b0}}, sr_ff[7:0]};
   assign hash_in = WORD_W'(mix_x * FNV_PRIME_LOW) +
                    {mix_x[WORD_W-1-FNV_PRIME_SHIFT:0], {FNV_PRIME_SHIFT{1'b0}}};

   assign sr_in = {8'h00, sr_ff[SR_W-1:8]};

   assign cnt_in   = in_range_ff ? ((rd_vld_ff ? rd_data_ff : '0) + WORD_W'(1)) : '0;
   assign next_sum = {1'b0, next_point_ff} + {1'b0, interval_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_HASH;
         end
         ST_HASH: begin
            if (last_step) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state, counters and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         interval_ff    <= INTERVAL_RESET;
         stop_count_ff  <= '0;
         watch_pc_ff    <= ALL_ONES;
         hash_ff        <= FNV_OFFSET;
         total_ff       <= '0;
         next_point_ff  <= INTERVAL_RESET;
         stop_done_ff   <= 1'b0;
         watch_hit_ff   <= 1'b0;
         watch_count_ff <= ALL_ONES;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            case (csr_index)
               CSR_SAMPLE_INTERVAL: begin
                  interval_ff   <= csr_wdata;
                  next_point_ff <= csr_wdata;
               end
               CSR_STOP_COUNT: stop_count_ff <= csr_wdata;
               CSR_WATCH_PC:   watch_pc_ff   <= csr_wdata;
               default: ;
            endcase
         end

         if (accept) begin
            total_ff <= total_ff + WORD_W'(1);
            step_ff  <= '0;
         end else if (state_ff == ST_HASH) begin
            hash_ff <= hash_in;
            step_ff <= step_ff + STEP_W'(1);
         end

         // The total was bumped at accept, so the first hash cycle sees the
         // count that includes this instruction.
         if (first_step) begin
            if (!watch_hit_ff && (pc_ff == watch_pc_ff)) begin
               watch_hit_ff   <= 1'b1;
               watch_count_ff <= total_ff;
            end
            if ((stop_count_ff != '0) && (total_ff >= stop_count_ff) && !stop_done_ff)
               stop_done_ff <= 1'b1;
         end

         // The sample point advances in the cycle after the sample decision, saturating at all ones.
         if (second_step && sample_ff)
            next_point_ff <= next_sum[WORD_W] ? ALL_ONES : next_sum[WORD_W-1:0];

         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // Working registers that need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         sr_ff       <= {code_all[CODE_W-1:0],
                         {(WORD_W-LEN_W){1'b0}}, len_clamped,
                         req_insn_pc,
                         {(WORD_W-8){1'b0}}, req_cpu_index};
         nbytes_ff   <= STEP_W'(HDR_BYTES) + STEP_W'(len_clamped);
         pc_ff       <= req_insn_pc;
         cpu_ff      <= req_cpu_index[CPU_W-1:0];
         in_range_ff <= req_in_range;
      end else if (state_ff == ST_HASH) begin
         sr_ff <= sr_in;
      end

      if (first_step) begin
         cnt_ff    <= cnt_in;
         sample_ff <= (total_ff >= next_point_ff);
         stop_ff   <= (stop_count_ff != '0) && (total_ff >= stop_count_ff) &&
                      !stop_done_ff;
      end

      if (rsp_load) begin
         rsp_hash_ff        <= hash_ff;
         rsp_total_ff       <= total_ff;
         rsp_cnt_ff         <= cnt_ff;
         rsp_sample_ff      <= sample_ff;
         rsp_stop_ff        <= stop_ff;
         rsp_seen_ff        <= watch_hit_ff;
         rsp_watch_count_ff <= watch_count_ff;
      end
   end

   // Per-cpu counter memory: read at accept, written back on the first hash cycle.
   always_ff @(posedge clock) begin
      if (accept && req_in_range)
         rd_data_ff <= cpu_mem[req_cpu_index[CPU_W-1:0]];
      if (first_step && in_range_ff)
         cpu_mem[cpu_ff] <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (accept)
            rd_vld_ff <= req_in_range && cpu_vld_ff[req_cpu_index[CPU_W-1:0]];
         if (first_step && in_range_ff)
            cpu_vld_ff[cpu_ff] <= 1'b1;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_stream_fingerprint = rsp_hash_ff;
   assign rsp_retired_total      = rsp_total_ff;
   assign rsp_cpu_retired        = rsp_cnt_ff;
   assign rsp_sample_due         = rsp_sample_ff;
   assign rsp_stop_hit           = rsp_stop_ff;
   assign rsp_watch_seen         = rsp_seen_ff;
   assign rsp_watch_first_count  = rsp_watch_count_ff;

   // A new result only appears straight after the settle cycle.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result became valid outside the settle cycle");

   // The byte counter never runs past the bytes of the current request.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HASH) |-> (step_ff < nbytes_ff))
      else $error("hash step beyond request length");

   // A stop flag on a result implies the one-shot stop has been latched.
   a_stop_latched: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stop_ff) |-> stop_done_ff)
      else $error("stop reported without stop latched");

   // Until the watched pc retires, the recorded count stays all ones.
   a_watch_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_seen_ff) |-> (rsp_watch_count_ff == ALL_ONES))
      else $error("watch count set without watch hit");

endmodule

`default_nettype wire
